FILE: rtl/core/bb3_pkg.sv
// Package for the 3x3 box blur stream: sizes, register indexes and command codes.
// Used by the box_blur_3x3_stream top level. No dependencies.
package bb3_pkg;

  localparam int unsigned MAX_WIDTH   = 1024;
  // The pixel history must span two rows plus three pixels; it is addressed by
  // raster index modulo a power of two, so pointer wrap is free.
  localparam int unsigned ADDR_W      = $clog2(2 * MAX_WIDTH + 3);
  localparam int unsigned STORE_DEPTH = 1 << ADDR_W;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PIX_W   = 3 * CHAN_W;
  localparam int unsigned CFG_W_W = 11;
  localparam int unsigned CFG_H_W = 12;
  localparam int unsigned CFG_D_W = 12;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned FW_W    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PEND_W  = $clog2(MAX_WIDTH + 3);
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned REM_W   = SUM_W + 1;
  localparam int unsigned DVS_W   = CNT_W + 1;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 12'd480;

  // Configuration register indexes.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Input item kinds carried in tuser.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [PIX_W-1:0]  pix_t;

endpackage

FILE: rtl/core/bb3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bb3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/box_blur_3x3_stream.sv
// Top level of the 3x3 box blur over an RGB pixel stream.
// Depends on bb3_pkg and on the bb3_ram pixel history memory.
//
// Usage:
//   Pixels enter on the slave stream in raster order (tuser = 0); tuser = 1
//   marks a drain item that releases one pending result after the frame is in.
//   Frame size comes from the configuration port and is sampled on the first
//   pixel of each frame. Each result is the rounded mean of the pixel's 3x3
//   neighborhood inside the frame; tlast marks the last pixel of the frame.
//   Result q appears once pixel q + W + 1 is in, so W + 1 drains flush a frame.
// Sequencing:
//   An item that releases no result leaves the block ready for the next one.
//   An item that releases a result starts 9 reads of the single read port of
//   the history RAM; then the last read data is summed, the division is set up,
//   8 steps of a one-bit-per-cycle divider run and the result moves to the
//   output register. The next item is taken while that result waits for tready.
//   If the output register is still full when a new result is ready, the
//   block holds and takes no item until the receiver accepts it.
// Reset: asynchronous and active low; positions clear, registers return to
//   640 x 480 and the output empties. The memory needs no clearing pass.
module box_blur_3x3_stream
  import bb3_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [CFG_D_W-1:0] cfg_data_i,
  // Input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [PIX_W-1:0]   s_axis_tdata,   // in_red, in_green, in_blue
  input  logic               s_axis_tuser,   // cmd
  // Output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [PIX_W-1:0]   m_axis_tdata,   // out_red, out_green, out_blue
  output logic               m_axis_tlast    // frame_end
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_LAST = 6'b000100,
    S_PREP = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W_W-1:0] width_q;
  logic [CFG_H_W-1:0] height_q;
  logic [FW_W-1:0]    fw_q, fw_d;
  logic [ROW_W-1:0]   fh_q, fh_d;
  logic [ROW_W-1:0]   in_row_q, in_row_d;
  logic [COL_W-1:0]   in_col_q, in_col_d;
  logic [ROW_W-1:0]   out_row_q, out_row_d;
  logic [COL_W-1:0]   out_col_q, out_col_d;
  logic [ADDR_W-1:0]  wa_q, wa_d;
  logic [ADDR_W-1:0]  oa_q, oa_d;
  logic [PEND_W-1:0]  pend_q, pend_d;

  // Snapshot of the pixel whose neighborhood is being averaged.
  logic [ADDR_W-1:0]  ca_q, ca_d;
  logic               row_lo_q, row_hi_q, col_lo_q, col_hi_q, last_q;
  logic               row_lo_d, row_hi_d, col_lo_d, col_hi_d, last_d;
  logic               produce;

  logic [1:0]         nr_q, nc_q;
  logic               rd_vld_q;
  logic [SUM_W-1:0]   sum_q [3];
  logic [CNT_W-1:0]   cnt_q;
  logic [REM_W-1:0]   rem_q [3];
  chan_t              quo_q [3];
  logic [2:0]         step_q;

  logic               m_vld_q;
  pix_t               m_data_q;
  logic               m_last_q;

  logic               in_acc;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  pix_t               ram_rdata;
  logic               nb_vld;
  logic               out_load;
  logic [DVS_W-1:0]   dvs;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!m_vld_q || m_axis_tready);
  assign dvs           = {cnt_q, 1'b0};

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[CFG_W_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame bookkeeping on an accepted item: write the pixel, decide whether a
  // result is due and advance the input and output positions.
  always_comb begin
    logic              active;
    logic              all_in;
    logic              is_pix;
    logic              act2;
    logic              all2;
    logic [FW_W-1:0]   eff_w;
    logic [ROW_W-1:0]  eff_h;
    logic [FW_W-1:0]   fw_use;
    logic [ROW_W-1:0]  fh_use;
    logic [ROW_W-1:0]  orow_c;
    logic [COL_W-1:0]  ocol_c;
    logic [ADDR_W-1:0] wa_c;
    logic [ADDR_W-1:0] oa_c;
    logic [PEND_W-1:0] pend_c;
    logic [PEND_W-1:0] pend_n;

    active = (in_row_q != '0) || (in_col_q != '0);
    all_in = active && (in_row_q >= fh_q);
    is_pix = (s_axis_tuser == CMD_PIXEL) && !all_in;

    if (width_q == '0) begin
      eff_w = FW_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = FW_W'(MAX_WIDTH);
    end else begin
      eff_w = FW_W'(width_q);
    end
    eff_h = (height_q == '0) ? ROW_W'(1) : ROW_W'(height_q);

    fw_use = active ? fw_q : eff_w;
    fh_use = active ? fh_q : eff_h;
    orow_c = active ? out_row_q : '0;
    ocol_c = active ? out_col_q : '0;
    wa_c   = active ? wa_q : '0;
    oa_c   = active ? oa_q : '0;
    pend_c = active ? pend_q : '0;
    ca_d   = oa_c;

    fw_d      = fw_q;
    fh_d      = fh_q;
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    wa_d      = wa_q;
    oa_d      = oa_q;
    pend_d    = pend_q;
    ram_we    = 1'b0;
    ram_waddr = wa_c;
    pend_n    = pend_c;

    if (in_acc && is_pix) begin
      fw_d      = fw_use;
      fh_d      = fh_use;
      out_row_d = orow_c;
      out_col_d = ocol_c;
      oa_d      = oa_c;
      ram_we    = 1'b1;
      wa_d      = wa_c + ADDR_W'(1);
      pend_n    = pend_c + PEND_W'(1);
      pend_d    = pend_n;
      if ((FW_W'(in_col_q) + FW_W'(1)) >= fw_use) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
    end

    act2     = active || is_pix;
    all2     = act2 && (in_row_d >= fh_use);
    produce  = in_acc && act2 &&
               (all2 || (pend_n >= (PEND_W'(fw_use) + PEND_W'(2))));

    row_lo_d = (orow_c != '0);
    row_hi_d = ((orow_c + ROW_W'(1)) < fh_use);
    col_lo_d = (ocol_c != '0);
    col_hi_d = ((FW_W'(ocol_c) + FW_W'(1)) < fw_use);
    last_d   = !row_hi_d && !col_hi_d;

    if (produce) begin
      if (last_d) begin
        in_row_d  = '0;
        in_col_d  = '0;
        out_row_d = '0;
        out_col_d = '0;
        wa_d      = '0;
        oa_d      = '0;
        pend_d    = '0;
      end else begin
        oa_d   = oa_c + ADDR_W'(1);
        pend_d = pend_n - PEND_W'(1);
        if (col_hi_d) begin
          out_col_d = ocol_c + COL_W'(1);
        end else begin
          out_col_d = '0;
          out_row_d = orow_c + ROW_W'(1);
        end
      end
    end
  end

  // Neighbor address: center address moved by one row and one column.
  always_comb begin
    logic [ADDR_W-1:0] base;
    case (nr_q)
      2'd0:    base = ca_q - ADDR_W'(fw_q);
      2'd2:    base = ca_q + ADDR_W'(fw_q);
      default: base = ca_q;
    endcase
    case (nc_q)
      2'd0:    ram_raddr = base - ADDR_W'(1);
      2'd2:    ram_raddr = base + ADDR_W'(1);
      default: ram_raddr = base;
    endcase
    nb_vld = ((nr_q != 2'd0) || row_lo_q) && ((nr_q != 2'd2) || row_hi_q) &&
             ((nc_q != 2'd0) || col_lo_q) && ((nc_q != 2'd2) || col_hi_q);
  end

  assign ram_re = (state_q == S_READ);

  bb3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (produce) state_d = S_READ;
      S_READ: if (nr_q == 2'd2 && nc_q == 2'd2) state_d = S_LAST;
      S_LAST: state_d = S_PREP;
      S_PREP: state_d = S_DIV;
      S_DIV:  if (step_q == 3'd0) state_d = S_DONE;
      S_DONE: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fw_q      <= '0;
      fh_q      <= '0;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      wa_q      <= '0;
      oa_q      <= '0;
      pend_q    <= '0;
      nr_q      <= '0;
      nc_q      <= '0;
      rd_vld_q  <= 1'b0;
      step_q    <= '0;
      m_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      fw_q      <= fw_d;
      fh_q      <= fh_d;
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
      wa_q      <= wa_d;
      oa_q      <= oa_d;
      pend_q    <= pend_d;
      rd_vld_q  <= (state_q == S_READ) && nb_vld;
      if (produce) begin
        nr_q <= '0;
        nc_q <= '0;
      end else if (state_q == S_READ) begin
        if (nc_q == 2'd2) begin
          nc_q <= '0;
          nr_q <= nr_q + 2'd1;
        end else begin
          nc_q <= nc_q + 2'd1;
        end
      end
      if (state_q == S_PREP) begin
        step_q <= 3'd7;
      end else if (state_q == S_DIV) begin
        step_q <= step_q - 3'd1;
      end
      if (out_load) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // Datapath: neighbor sums, restoring division and the output register.
  always_ff @(posedge clk_i) begin
    logic [REM_W-1:0] dsh;
    if (produce) begin
      ca_q     <= ca_d;
      row_lo_q <= row_lo_d;
      row_hi_q <= row_hi_d;
      col_lo_q <= col_lo_d;
      col_hi_q <= col_hi_d;
      last_q   <= last_d;
      cnt_q    <= '0;
    end
    if ((state_q == S_READ || state_q == S_LAST) && rd_vld_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
    dsh = REM_W'(dvs) << step_q;
    for (int c = 0; c < 3; c++) begin
      if (produce) begin
        sum_q[c] <= '0;
      end else if ((state_q == S_READ || state_q == S_LAST) && rd_vld_q) begin
        sum_q[c] <= sum_q[c] + SUM_W'(ram_rdata[c*CHAN_W +: CHAN_W]);
      end
      if (state_q == S_PREP) begin
        rem_q[c] <= {sum_q[c], 1'b0} + REM_W'(cnt_q);
        quo_q[c] <= '0;
      end else if (state_q == S_DIV) begin
        if (rem_q[c] >= dsh) begin
          rem_q[c]         <= rem_q[c] - dsh;
          quo_q[c][step_q] <= 1'b1;
        end
      end
    end
    if (out_load) begin
      m_data_q <= {quo_q[2], quo_q[1], quo_q[0]};
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // A new result enters the output register only from the final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
    else $error("output became valid outside the result handoff");

  // The center pixel always lies in the frame, so the divisor is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PREP) |-> (cnt_q != '0))
    else $error("empty neighborhood at division setup");

  // The divider runs exactly eight steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && step_q == 3'd0) |=> (state_q == S_DONE))
    else $error("divider did not finish after its last step");

  // The input never runs more than a row and two pixels ahead of the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q <= (PEND_W'(fw_q) + PEND_W'(2))))
    else $error("pending pixel count beyond the window span");

endmodule

FILE: bench/box_blur_3x3_stream_tb.sv
// Self-checking testbench for box_blur_3x3_stream: random bursts of pixels and drains,
// a cycle-accurate-free predictor of the blurred frame and an in-order result check.
// Depends on bb3_pkg and the box_blur_3x3_stream RTL.
module box_blur_3x3_stream_tb;
  import bb3_pkg::*;

  localparam int unsigned HIST_DEPTH  = 2 * MAX_WIDTH + 3;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RAND_ITEMS  = 1600;
  localparam int unsigned PRINT_CAP   = 100;

  // Red sits in the low byte, as on the bus.
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } rgb_t;

  typedef struct packed {
    logic drain;
    rgb_t px;
  } feed_item_t;

  typedef struct packed {
    logic frame_end;
    rgb_t px;
  } blur_out_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic               cfg_idx_i     = REG_IMAGE_WIDTH;
  logic [CFG_D_W-1:0] cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [PIX_W-1:0]   s_axis_tdata  = '0;  // in_red, in_green, in_blue
  logic               s_axis_tuser  = CMD_PIXEL;  // cmd
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [PIX_W-1:0]   m_axis_tdata;  // out_red, out_green, out_blue
  logic               m_axis_tlast;  // frame_end

  box_blur_3x3_stream dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  feed_item_t  pixel_feed[$];
  blur_out_t   pending_blur[$];

  // Predictor state: pixel history, positions and the registers as the block holds them.
  rgb_t               hist[HIST_DEPTH];
  int unsigned        in_col, in_row, out_col, out_row, frm_w, frm_h;
  logic [CFG_W_W-1:0] reg_width;
  logic [CFG_H_W-1:0] reg_height;

  int unsigned mismatches, pixels_in, drains_in, results_out, frames_out, reg_writes;
  int unsigned frame_items, cycle_count;
  int unsigned burst_left, gap_left;
  int unsigned hold_requests, holds_served, hold_left, stall_span, stall_pct;
  logic        in_taken = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Advances the blur by one accepted item; returns 1 when the item releases a result.
  function automatic bit blur_step(input bit drain, input rgb_t px, output blur_out_t res);
    bit          active, all_in;
    int unsigned received, q, cnt, sr, sg, sb;
    int          r, c;
    rgb_t        v;
    active = (in_row != 0) || (in_col != 0);
    all_in = active && (in_row >= frm_h);
    res = '0;
    if (!drain && !all_in) begin
      if (!active) begin
        // Frame size is latched by the first pixel of the frame.
        frm_w   = (reg_width == 0) ? 1 : (reg_width > MAX_WIDTH) ? MAX_WIDTH : reg_width;
        frm_h   = (reg_height == 0) ? 1 : reg_height;
        out_row = 0;
        out_col = 0;
      end
      hist[(in_row * frm_w + in_col) % HIST_DEPTH] = px;
      in_col++;
      if (in_col >= frm_w) begin
        in_col = 0;
        in_row++;
      end
      active = 1'b1;
      all_in = (in_row >= frm_h);
    end
    if (!active) return 1'b0;
    received = in_row * frm_w + in_col;
    q        = out_row * frm_w + out_col;
    if (!all_in && received < q + frm_w + 2) return 1'b0;
    cnt = 0;
    sr  = 0;
    sg  = 0;
    sb  = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        r = int'(out_row) + dr;
        c = int'(out_col) + dc;
        if (r >= 0 && c >= 0 && r < int'(frm_h) && c < int'(frm_w)) begin
          v = hist[(r * int'(frm_w) + c) % HIST_DEPTH];
          sr += v.red;
          sg += v.green;
          sb += v.blue;
          cnt++;
        end
      end
    end
    res.px.red   = chan_t'((2 * sr + cnt) / (2 * cnt));
    res.px.green = chan_t'((2 * sg + cnt) / (2 * cnt));
    res.px.blue  = chan_t'((2 * sb + cnt) / (2 * cnt));
    if (out_row + 1 >= frm_h && out_col + 1 >= frm_w) begin
      res.frame_end = 1'b1;
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
    end else begin
      out_col++;
      if (out_col >= frm_w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  function automatic rgb_t rand_rgb();
    logic [PIX_W-1:0] v;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 7))
        0:       v[i*CHAN_W +: CHAN_W] = '0;
        1:       v[i*CHAN_W +: CHAN_W] = '1;
        default: v[i*CHAN_W +: CHAN_W] = CHAN_W'($urandom_range(0, 255));
      endcase
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_D_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic push_px(input bit drain, input chan_t r, input chan_t g, input chan_t b);
    rgb_t px;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    pixel_feed.push_back('{drain: drain, px: px});
  endtask

  // One whole frame of w x h pixels plus the items that flush its pending results.
  // In noisy mode, drains that do nothing are sprinkled in and some flush items
  // are pixels, which the block treats as drains once the frame is in.
  task automatic queue_frame(input int unsigned w, input int unsigned h, input bit noisy);
    int unsigned n, pend;
    n    = w * h;
    pend = (n < w + 1) ? n : w + 1;
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) pixel_feed.push_back('{drain: 1'b1, px: rand_rgb()});
      pixel_feed.push_back('{drain: 1'b0, px: rand_rgb()});
    end
    for (int unsigned i = 0; i < pend; i++) begin
      pixel_feed.push_back('{drain: !(noisy && $urandom_range(0, 9) == 0), px: rand_rgb()});
    end
    if (noisy && $urandom_range(0, 3) == 0) pixel_feed.push_back('{drain: 1'b1, px: rand_rgb()});
    frame_items += n + pend;
  endtask

  // Sender pause: every item taken, every result back, then time for the block to go quiet.
  task automatic settle();
    while (pixel_feed.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (pending_blur.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Stimulus sender: bursts of transfers separated by random gaps.
  always @(negedge clk_i) begin
    feed_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_feed.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        it = pixel_feed.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.drain ? CMD_DRAIN : CMD_PIXEL;
        s_axis_tdata  <= it.px;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // Result receiver: stall density changes from span to span; a requested hold
  // keeps tready low long enough for the block to back up onto its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_span = $urandom_range(16, 200);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      stall_span--;
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: register writes and input transfers feed the predictor, output
  // transfers are checked against the oldest expected result.
  always @(posedge clk_i) begin
    blur_out_t want, got;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (cfg_we_i) begin
        reg_writes++;
        if (cfg_idx_i == REG_IMAGE_WIDTH) reg_width = cfg_data_i[CFG_W_W-1:0];
        else reg_height = cfg_data_i[CFG_H_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CMD_DRAIN) drains_in++;
        else pixels_in++;
        if (blur_step(s_axis_tuser == CMD_DRAIN, s_axis_tdata, want)) pending_blur.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.px        = m_axis_tdata;
        got.frame_end = m_axis_tlast;
        results_out++;
        if (got.frame_end) frames_out++;
        if (pending_blur.size() == 0) begin
          report_mismatch($sformatf("result %h last=%b with nothing expected",
                                    got.px, got.frame_end));
        end else begin
          want = pending_blur.pop_front();
          if (got.px.red !== want.px.red)
            report_mismatch($sformatf("result %0d red %h, expected %h",
                                      results_out, got.px.red, want.px.red));
          if (got.px.green !== want.px.green)
            report_mismatch($sformatf("result %0d green %h, expected %h",
                                      results_out, got.px.green, want.px.green));
          if (got.px.blue !== want.px.blue)
            report_mismatch($sformatf("result %0d blue %h, expected %h",
                                      results_out, got.px.blue, want.px.blue));
          if (got.frame_end !== want.frame_end)
            report_mismatch($sformatf("result %0d frame_end %b, expected %b",
                                      results_out, got.frame_end, want.frame_end));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending_blur.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned w, h;
    in_col     = 0;
    in_row     = 0;
    out_col    = 0;
    out_row    = 0;
    frm_w      = 0;
    frm_h      = 0;
    reg_width  = WIDTH_RESET;
    reg_height = HEIGHT_RESET;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // 3x2 frame with channel extremes: a drain while idle, a drain mid-frame
    // that releases nothing, and a pixel in the flush that acts as a drain.
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 2);
    push_px(1'b1, 8'h00, 8'h00, 8'h00);
    push_px(1'b0, 8'hff, 8'hff, 8'hff);
    push_px(1'b0, 8'h00, 8'h00, 8'h00);
    push_px(1'b1, 8'h00, 8'h00, 8'h00);
    push_px(1'b0, 8'hff, 8'h00, 8'haa);
    push_px(1'b0, 8'h55, 8'hff, 8'h00);
    push_px(1'b0, 8'h01, 8'h80, 8'hfe);
    push_px(1'b0, 8'hff, 8'hff, 8'hff);
    push_px(1'b0, 8'h12, 8'h34, 8'h56);
    repeat (3) push_px(1'b1, 8'h00, 8'h00, 8'h00);
    push_px(1'b0, 8'hff, 8'hff, 8'hff);
    settle();

    // Registers change twice inside the 3x2 frame begun by the last pixel above;
    // neither new size (1x1 written as zero) applies to it; the next test flushes it.
    write_reg(REG_IMAGE_WIDTH, 2);
    write_reg(REG_IMAGE_HEIGHT, 2);
    push_px(1'b0, 8'h10, 8'h20, 8'h30);
    push_px(1'b0, 8'hff, 8'h00, 8'h7f);
    settle();
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    push_px(1'b0, 8'h80, 8'hff, 8'h01);
    push_px(1'b0, 8'h00, 8'h01, 8'hff);
    repeat (3) push_px(1'b1, 8'h00, 8'h00, 8'h00);
    push_px(1'b0, 8'hc3, 8'h3c, 8'h99);
    settle();

    // Receiver holds off while the sender keeps offering a 16x6 frame.
    write_reg(REG_IMAGE_WIDTH, 16);
    write_reg(REG_IMAGE_HEIGHT, 6);
    queue_frame(16, 6, 1'b0);
    hold_requests++;
    settle();

    // Random frame sizes, mostly small, a few frames per setting.
    frame_items = 0;
    while (frame_items < RAND_ITEMS) begin
      if ($urandom_range(0, 14) == 0) w = $urandom_range(13, 64);
      else w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      write_reg(REG_IMAGE_WIDTH, (w == 1 && $urandom_range(0, 3) == 0) ? 0 : w);
      write_reg(REG_IMAGE_HEIGHT, (h == 1 && $urandom_range(0, 3) == 0) ? 0 : h);
      repeat ($urandom_range(1, 3)) queue_frame(w, h, 1'b1);
      settle();
    end

    $display("Covered %0d pixel and %0d drain transfers, %0d results in %0d frames,",
             pixels_in, drains_in, results_out, frames_out);
    $display("%0d register writes, sizes from 1x1 up to 64 wide and 10 tall, %0d mismatches.",
             reg_writes, mismatches);
    if (mismatches == 0 && pending_blur.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
